>>> rtl/core/pstd_pkg.sv
// Shared types and constants of the PCM sample to binary64 converter.
// Depends on nothing; every other file imports it.
`default_nettype none

package pstd_pkg;

  // Sample format codes held in the format register
  typedef enum logic [3:0] {
    FMT_S8    = 4'd0,
    FMT_U8    = 4'd1,
    FMT_S16LE = 4'd2,
    FMT_S16BE = 4'd3,
    FMT_U16LE = 4'd4,
    FMT_U16BE = 4'd5,
    FMT_S32LE = 4'd6,
    FMT_S32BE = 4'd7,
    FMT_U32LE = 4'd8,
    FMT_U32BE = 4'd9,
    FMT_F32LE = 4'd10,
    FMT_F32BE = 4'd11,
    FMT_F64LE = 4'd12,
    FMT_F64BE = 4'd13
  } fmt_e;

  localparam fmt_e FMT_RESET = FMT_S16LE;

  // Integer sample width
  typedef enum logic [1:0] {
    W_8  = 2'd0,
    W_16 = 2'd1,
    W_32 = 2'd2
  } width_e;

  // Result kind: finished bit pattern, or a repeating quotient to round
  typedef enum logic {
    K_BITS = 1'b0,
    K_REP  = 1'b1
  } kind_e;

  localparam logic [31:0] FULL_SCALE_S8  = 32'd127;
  localparam logic [31:0] FULL_SCALE_S16 = 32'd32767;
  localparam logic [31:0] FULL_SCALE_S32 = 32'h7FFF_FFFF;
  localparam logic [10:0] EXP_ONE   = 11'd1023;
  localparam logic [10:0] EXP_F32   = 11'd896;

  // Classified request passed from front to back
  typedef struct packed {
    kind_e       kind;
    width_e      wd;
    logic        sign;
    logic [10:0] exp;
    logic [30:0] blk;
    logic [4:0]  sh;
    logic [63:0] bits;
  } op_t;

endpackage

`default_nettype wire

>>> rtl/core/pstd_front.sv
// Front end: accepts raw samples, orders bytes and classifies each request.
// Depends on pstd_pkg.
`default_nettype none

module pstd_front import pstd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire fmt_e        fmt_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] in_raw_i,
  output logic             op_valid_o,
  input  wire logic        op_ready_i,
  output op_t              op_o
);

  logic        fv_q, fv_d;
  op_t         op_q, op_d;
  logic [15:0] h16;
  logic [31:0] w32;
  logic [7:0]  b8;
  logic        is_int;
  width_e      wd;
  logic [31:0] sv, mag, dmax;
  logic [30:0] a31;
  logic [4:0]  lz;
  logic        found;
  logic [63:0] fbits;
  logic        fs;
  logic [7:0]  fe;
  logic [22:0] fm, ffrac;
  logic [4:0]  lz2;
  logic        found2;

  // Byte order and unsigned flip
  always_comb begin
    b8  = in_raw_i[7:0] ^ {(fmt_i == FMT_U8), 7'b0};
    h16 = ((fmt_i == FMT_S16BE) || (fmt_i == FMT_U16BE)) ?
          {in_raw_i[7:0], in_raw_i[15:8]} : in_raw_i[15:0];
    h16 = h16 ^ {((fmt_i == FMT_U16LE) || (fmt_i == FMT_U16BE)), 15'b0};
    w32 = ((fmt_i == FMT_S32BE) || (fmt_i == FMT_U32BE) || (fmt_i == FMT_F32BE)) ?
          {in_raw_i[7:0], in_raw_i[15:8], in_raw_i[23:16], in_raw_i[31:24]} :
          in_raw_i[31:0];
  end

  // Widen float32 exactly
  always_comb begin
    fs     = w32[31];
    fe     = w32[30:23];
    fm     = w32[22:0];
    lz2    = '0;
    found2 = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found2 && fm[i]) begin
        lz2    = 5'(22 - i);
        found2 = 1'b1;
      end
    end
    ffrac = 23'(fm << (lz2 + 5'd1));
    if (fe == 8'hFF) begin
      fbits = {fs, 11'h7FF, fm, 29'b0};
      fbits[51] = fbits[51] | (fm != '0);
    end else if (fe == 8'h00) begin
      if (fm == '0) fbits = {fs, 63'b0};
      else          fbits = {fs, EXP_F32 - 11'(lz2), ffrac, 29'b0};
    end else begin
      fbits = {fs, 11'(fe) + EXP_F32, fm, 29'b0};
    end
  end

  // Select the path by format
  always_comb begin
    is_int = 1'b1;
    wd     = W_8;
    sv     = '0;
    op_d   = '0;
    unique case (fmt_i)
      FMT_S8, FMT_U8: begin
        sv = {{24{b8[7]}}, b8};
      end
      FMT_S16LE, FMT_S16BE, FMT_U16LE, FMT_U16BE: begin
        wd = W_16;
        sv = {{16{h16[15]}}, h16};
      end
      FMT_S32LE, FMT_S32BE, FMT_U32LE, FMT_U32BE: begin
        wd = W_32;
        sv = w32 ^ {((fmt_i == FMT_U32LE) || (fmt_i == FMT_U32BE)), 31'b0};
      end
      FMT_F32LE, FMT_F32BE: begin
        is_int       = 1'b0;
        op_d.bits    = fbits;
      end
      FMT_F64LE: begin
        is_int       = 1'b0;
        op_d.bits    = in_raw_i;
      end
      FMT_F64BE: begin
        is_int       = 1'b0;
        for (int i = 0; i < 8; i++) op_d.bits[8*i +: 8] = in_raw_i[8*(7-i) +: 8];
      end
      default: begin
        is_int       = 1'b0;
        op_d.bits    = '0;
      end
    endcase

    mag = sv[31] ? (~sv + 32'd1) : sv;
    unique case (wd)
      W_8:     begin dmax = FULL_SCALE_S8;  a31 = {mag[6:0], 24'b0};  end
      W_16:    begin dmax = FULL_SCALE_S16; a31 = {mag[14:0], 16'b0}; end
      W_32:    begin dmax = FULL_SCALE_S32; a31 = mag[30:0];          end
      default: begin dmax = FULL_SCALE_S32; a31 = mag[30:0];          end
    endcase

    // Find the leading one of the magnitude
    lz    = '0;
    found = 1'b0;
    for (int i = 30; i >= 0; i--) begin
      if (!found && a31[i]) begin
        lz    = 5'(30 - i);
        found = 1'b1;
      end
    end

    if (is_int) begin
      op_d.wd   = wd;
      op_d.sign = sv[31];
      if (mag == '0) begin
        op_d.kind = K_BITS;
        op_d.bits = '0;
      end else if (mag == dmax) begin
        op_d.kind = K_BITS;
        op_d.bits = {sv[31], EXP_ONE, 52'b0};
      end else if (mag == dmax + 32'd1) begin
        // Most negative code: one plus the repeating 1/max pattern
        op_d.kind = K_REP;
        op_d.exp  = EXP_ONE;
        op_d.blk  = 31'd1;
        op_d.sh   = '0;
      end else begin
        op_d.kind = K_REP;
        op_d.exp  = (EXP_ONE - 11'd1) - 11'(lz);
        op_d.blk  = mag[30:0];
        op_d.sh   = lz + 5'd1;
      end
    end else begin
      op_d.kind = K_BITS;
    end
  end

  // Hold the classified request until the queue takes it
  assign in_ready_o = !fv_q || op_ready_i;
  assign op_valid_o = fv_q;
  assign op_o       = op_q;

  always_comb begin
    if (in_valid_i && in_ready_o) fv_d = 1'b1;
    else if (op_ready_i)          fv_d = 1'b0;
    else                          fv_d = fv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= op_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pstd_queue.sv
// Short request queue between front and back.
// Depends on pstd_pkg.
`default_nettype none

module pstd_queue import pstd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire op_t  push_op_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output op_t       pop_op_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_t           mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_op_o     = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    if (pop)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    if (push && !pop)      cnt_d = cnt_q + CW'(1);
    else if (pop && !push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pstd_back.sv
// Back end: expands the repeating quotient, rounds and packs binary64.
// Depends on pstd_pkg.
`default_nettype none

module pstd_back import pstd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        op_valid_i,
  output logic             op_ready_o,
  input  wire op_t         op_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_bits_o
);

  logic        ov_q, ov_d;
  logic [63:0] res_q, res_d;
  logic [13:0] y7;
  logic [29:0] y15;
  logic [61:0] y31;
  logic [6:0]  r7;
  logic [14:0] r15;
  logic [30:0] r31;
  logic [52:0] f;
  logic [51:0] mant;

  // Rotate the block so the stream starts after the leading one
  always_comb begin
    y7  = {op_i.blk[6:0], op_i.blk[6:0]} << op_i.sh;
    y15 = {op_i.blk[14:0], op_i.blk[14:0]} << op_i.sh;
    y31 = {op_i.blk, op_i.blk} << op_i.sh;
    r7  = y7[13:7];
    r15 = y15[29:15];
    r31 = y31[61:31];
  end

  // Repeat the block, round to nearest (never a tie) and pack
  always_comb begin
    f = '0;
    unique case (op_i.wd)
      W_8:     for (int j = 0; j < 53; j++) f[52-j] = r7[6 - (j % 7)];
      W_16:    for (int j = 0; j < 53; j++) f[52-j] = r15[14 - (j % 15)];
      W_32:    for (int j = 0; j < 53; j++) f[52-j] = r31[30 - (j % 31)];
      default: f = '0;
    endcase
    mant = f[52:1] + {51'b0, f[0]};
    unique case (op_i.kind)
      K_BITS:  res_d = op_i.bits;
      K_REP:   res_d = {op_i.sign, op_i.exp, mant};
      default: res_d = '0;
    endcase
  end

  // Output register
  assign op_ready_o  = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_bits_o  = res_q;

  always_comb begin
    if (op_valid_i && op_ready_o) ov_d = 1'b1;
    else if (out_ready_i)         ov_d = 1'b0;
    else                          ov_d = ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_ready_o) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pcm_sample_to_double.sv
// Top level of the PCM sample to binary64 converter.
// Depends on pstd_pkg, pstd_front, pstd_queue and pstd_back.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[63:0] raw_bytes
//  m_axis   | out       | tdata[63:0] value_bits
//  cfg      | in        | cfg_wdata_i[3:0] sample_format
//
// One sample per cycle sustained while the output is not stalled; the result is
// offered after it passes the front register, a queue entry and the output register.
// Reset clears the format to S16LE and empties all stages.
// A stalled output fills the queue and then holds s_axis_tready low.
`default_nettype none

module pcm_sample_to_double import pstd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // raw_bytes
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // value_bits
);

  fmt_e fmt_q;
  logic op_valid, op_ready, q_valid, q_ready;
  op_t  op, q_op;

  // Format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RESET;
    end else if (cfg_we_i) begin
      fmt_q <= fmt_e'(cfg_wdata_i);
    end
  end

  pstd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fmt_i      (fmt_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_raw_i   (s_axis_tdata),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  pstd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (op_valid),
    .push_ready_o (op_ready),
    .push_op_i    (op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_op_o     (q_op)
  );

  pstd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_ready_o  (q_ready),
    .op_i        (q_op),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bits_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/pstd_checker.sv
// Port-level checks for the PCM sample to binary64 converter, bound to the top.
// Depends on pstd_pkg.
`default_nettype none

module pstd_checker import pstd_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [3:0]  cfg_wdata_i,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);

  logic [3:0] fmt_q;
  logic       is_int, is_undef;

  // Track the format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RESET;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  assign is_int   = (fmt_q < FMT_F32LE);
  assign is_undef = (fmt_q > FMT_F64BE);

  // Input stalls only while an output is pending
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output");

  // Held output stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  // Integer results stay within about one in magnitude
  a_int_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && is_int |-> m_axis_tdata[62:52] <= EXP_ONE)
    else $error("integer result out of range");

  // Undefined formats give positive zero
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && is_undef |-> m_axis_tdata == 64'd0)
    else $error("undefined format gave non-zero result");

endmodule

bind pcm_sample_to_double pstd_checker u_pstd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
